@@ sv/modbus_rtu_request_frame_checker_unit_assert.svh @@
// Assertion macros shared by the frame checker's assertion blocks.
`ifndef MODBUS_RTU_REQUEST_FRAME_CHECKER_UNIT_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAME_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MRFC_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("frame checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is low.
`define MRFC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("frame checker: next-cycle property failed");

`endif

@@ sv/mrfc_pkg.sv @@
// Shared types and constants of the Modbus RTU request frame checker.
package mrfc_pkg;

  localparam int ByteW = 8;
  localparam int CntW  = 9;
  localparam int CrcW  = 16;

  localparam logic [CntW-1:0] CntMax  = 9'd511;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // Supported function codes.
  localparam logic [ByteW-1:0] FcReadHolding = 8'h03;
  localparam logic [ByteW-1:0] FcWriteSingle = 8'h06;
  localparam logic [ByteW-1:0] FcWriteMulti  = 8'h10;
  localparam logic [ByteW-1:0] FcUser41      = 8'h41;

  // Byte positions that carry decoding information.
  localparam logic [CntW-1:0] IdxFuncCode  = 9'd1;
  localparam logic [CntW-1:0] IdxUserCount = 9'd2;
  localparam logic [CntW-1:0] IdxMultiCnt  = 9'd6;

  // Frame length rules.
  localparam logic [CntW-1:0] LenFixed     = 9'd8;
  localparam logic [CntW-1:0] LenMultiBase = 9'd9;
  localparam logic [CntW-1:0] LenUserBase  = 9'd5;
  localparam logic [CntW-1:0] LenCrcBytes  = 9'd2;

  typedef enum logic [1:0] {
    ST_SHORT       = 2'd0,
    ST_INCOMPLETE  = 2'd1,
    ST_COMPLETE    = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    status_t         status;
    logic [CntW-1:0] expected_length;
    logic            length_known;
    logic            crc_good;
    logic [CntW-1:0] bytes_seen;
  } out_item_t;

endpackage

@@ sv/mrfc_if.sv @@
// Request channel interfaces of the frame checker: byte input and result output.
interface mrfc_in_if;
  logic                           valid;
  logic                           ready;
  logic [mrfc_pkg::ByteW-1:0]     data_byte;
  logic                           frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface mrfc_out_if;
  logic                           valid;
  logic                           ready;
  mrfc_pkg::status_t              status;
  logic [mrfc_pkg::CntW-1:0]      expected_length;
  logic                           length_known;
  logic                           crc_good;
  logic [mrfc_pkg::CntW-1:0]      bytes_seen;

  modport source (output valid, output status, output expected_length,
                  output length_known, output crc_good, output bytes_seen, input ready);
  modport sink (input valid, input status, input expected_length,
                input length_known, input crc_good, input bytes_seen, output ready);
endinterface

@@ sv/modbus_rtu_request_frame_checker_unit.sv @@
// Top level of the Modbus RTU request frame checker.
//
//   Channel  | Role   | Payload
//   ---------+--------+----------------------------------------------------------
//   in_req   | sink   | data_byte[7:0], frame_start
//   out_rsp  | source | status[1:0], expected_length[8:0], length_known, crc_good, bytes_seen[8:0]
//
// One request byte is taken every cycle while in_req.ready is high; each gives one result,
// passing first through the input register and then through the result register.
// The byte-wide CRC update and length decode sit between those two registers.
// Reset (rst_n low, synchronous) empties both registers, restores the frame state
// and holds in_req.ready low.
// A stalled result holds its register; the input register still fills, and
// in_req.ready drops only when both registers are full.
module modbus_rtu_request_frame_checker_unit (
  input logic        clk,
  input logic        rst_n,
  mrfc_in_if.sink    in_req,
  mrfc_out_if.source out_rsp
);

  `include "modbus_rtu_request_frame_checker_unit_assert.svh"

  logic                s1_valid_r;
  mrfc_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  mrfc_pkg::out_item_t out_item_r;
  mrfc_pkg::out_item_t result;
  logic                out_adv;
  logic                step;
  logic                in_rdy;

  // Pipeline advance: result register free or being emptied.
  assign out_adv = !out_valid_r || out_rsp.ready;
  assign step    = s1_valid_r && out_adv;
  assign in_rdy  = rst_n && (!s1_valid_r || out_adv);
  assign in_req.ready = in_rdy;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_r <= in_req.valid;
    end
    if (in_rdy && in_req.valid) begin
      s1_item_r.data_byte   <= in_req.data_byte;
      s1_item_r.frame_start <= in_req.frame_start;
    end
  end

  mrfc_frame_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_item_r),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_item_r.status;
  assign out_rsp.expected_length = out_item_r.expected_length;
  assign out_rsp.length_known    = out_item_r.length_known;
  assign out_rsp.crc_good        = out_item_r.crc_good;
  assign out_rsp.bytes_seen      = out_item_r.bytes_seen;

  // Every result follows at least one counted byte.
  `MRFC_ASSERT_IMPLY(a_bytes_nonzero, clk, rst_n, out_rsp.valid, out_rsp.bytes_seen != '0)
  // A good CRC is only reported on a complete frame.
  `MRFC_ASSERT_IMPLY(a_crc_needs_complete, clk, rst_n,
                     out_rsp.valid && out_rsp.crc_good,
                     out_rsp.status == mrfc_pkg::ST_COMPLETE)
  // An unknown length reads as zero; a known one is at least the shortest frame.
  `MRFC_ASSERT_IMPLY(a_len_unknown_zero, clk, rst_n,
                     out_rsp.valid && !out_rsp.length_known,
                     out_rsp.expected_length == '0)
  `MRFC_ASSERT_IMPLY(a_len_known_min, clk, rst_n,
                     out_rsp.valid && out_rsp.length_known,
                     out_rsp.expected_length >= mrfc_pkg::LenUserBase)

endmodule

@@ sv/mrfc_crc8.sv @@
// Byte-wide Modbus CRC-16 update (reflected polynomial, eight bit steps unrolled).
module mrfc_crc8 (
  input  logic [mrfc_pkg::CrcW-1:0]  crc_in,
  input  logic [mrfc_pkg::ByteW-1:0] data,
  output logic [mrfc_pkg::CrcW-1:0]  crc_out
);

  // Fold the byte into the low half, then shift out eight bits.
  always_comb begin
    logic [mrfc_pkg::CrcW-1:0] c;
    c = crc_in ^ {{(mrfc_pkg::CrcW-mrfc_pkg::ByteW){1'b0}}, data};
    for (int k = 0; k < mrfc_pkg::ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mrfc_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

@@ sv/mrfc_frame_track.sv @@
// Frame state of the checker: byte count, length decode, CRC and result build.
module mrfc_frame_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  mrfc_pkg::in_item_t  item,
  output mrfc_pkg::out_item_t result
);

  logic [mrfc_pkg::CntW-1:0]  cnt_r, cnt_nxt, cnt_b;
  logic [mrfc_pkg::ByteW-1:0] fc_r, fc_nxt, fc_b;
  logic [mrfc_pkg::CntW-1:0]  len_r, len_nxt, len_b;
  logic                       lv_r, lv_nxt, lv_b;
  logic [mrfc_pkg::CrcW-1:0]  crc_r, crc_nxt, crc_b, crc_fed;
  logic [mrfc_pkg::ByteW-1:0] lo_r, lo_nxt, lo_b;
  logic                       match_r, match_nxt, match_b;
  logic                       proceed;
  logic                       crc_zone;
  logic                       complete;
  logic                       supported;
  logic [mrfc_pkg::ByteW-1:0] b;

  assign b = item.data_byte;

  // A frame start clears the state before the byte is taken as byte 0.
  always_comb begin
    if (item.frame_start) begin
      cnt_b   = '0;
      fc_b    = '0;
      len_b   = '0;
      lv_b    = 1'b0;
      crc_b   = mrfc_pkg::CrcInit;
      lo_b    = '0;
      match_b = 1'b0;
    end else begin
      cnt_b   = cnt_r;
      fc_b    = fc_r;
      len_b   = len_r;
      lv_b    = lv_r;
      crc_b   = crc_r;
      lo_b    = lo_r;
      match_b = match_r;
    end
  end

  assign proceed = item.frame_start || !(lv_b && (cnt_b >= len_b));

  mrfc_crc8 u_crc8 (
    .crc_in  (crc_b),
    .data    (b),
    .crc_out (crc_fed)
  );

  // Length decode, CRC feed or CRC capture, and counter advance.
  always_comb begin
    cnt_nxt   = cnt_b;
    fc_nxt    = fc_b;
    len_nxt   = len_b;
    lv_nxt    = lv_b;
    crc_nxt   = crc_b;
    lo_nxt    = lo_b;
    match_nxt = match_b;
    crc_zone  = 1'b0;
    if (proceed) begin
      if (cnt_b == mrfc_pkg::IdxFuncCode) begin
        fc_nxt = b;
        if (b == mrfc_pkg::FcReadHolding || b == mrfc_pkg::FcWriteSingle) begin
          len_nxt = mrfc_pkg::LenFixed;
          lv_nxt  = 1'b1;
        end
      end else if (cnt_b == mrfc_pkg::IdxUserCount && fc_b == mrfc_pkg::FcUser41) begin
        len_nxt = mrfc_pkg::LenUserBase + {1'b0, b};
        lv_nxt  = 1'b1;
      end else if (cnt_b == mrfc_pkg::IdxMultiCnt && fc_b == mrfc_pkg::FcWriteMulti) begin
        len_nxt = mrfc_pkg::LenMultiBase + {1'b0, b};
        lv_nxt  = 1'b1;
      end

      // The last two bytes are the received CRC, low byte first.
      crc_zone = lv_nxt && (len_nxt >= mrfc_pkg::LenCrcBytes) &&
                 (cnt_b >= len_nxt - mrfc_pkg::LenCrcBytes);
      if (crc_zone) begin
        if (cnt_b == len_nxt - mrfc_pkg::LenCrcBytes) begin
          lo_nxt = b;
        end else if (cnt_b == len_nxt - mrfc_pkg::CntW'(1)) begin
          match_nxt = (crc_b == {b, lo_b});
        end
      end else begin
        crc_nxt = crc_fed;
      end

      if (cnt_b < mrfc_pkg::CntMax) begin
        cnt_nxt = cnt_b + mrfc_pkg::CntW'(1);
      end
    end
  end

  // Result seen after this byte.
  assign complete  = lv_nxt && (cnt_nxt >= len_nxt);
  assign supported = (fc_nxt == mrfc_pkg::FcReadHolding) ||
                     (fc_nxt == mrfc_pkg::FcWriteSingle) ||
                     (fc_nxt == mrfc_pkg::FcWriteMulti) ||
                     (fc_nxt == mrfc_pkg::FcUser41);

  always_comb begin
    priority if (cnt_nxt < mrfc_pkg::LenCrcBytes) begin
      result.status = mrfc_pkg::ST_SHORT;
    end else if (!supported) begin
      result.status = mrfc_pkg::ST_UNSUPPORTED;
    end else if (complete) begin
      result.status = mrfc_pkg::ST_COMPLETE;
    end else begin
      result.status = mrfc_pkg::ST_INCOMPLETE;
    end
    result.expected_length = lv_nxt ? len_nxt : '0;
    result.length_known    = lv_nxt;
    result.crc_good        = complete && match_nxt;
    result.bytes_seen      = cnt_nxt;
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      fc_r    <= '0;
      len_r   <= '0;
      lv_r    <= 1'b0;
      crc_r   <= mrfc_pkg::CrcInit;
      lo_r    <= '0;
      match_r <= 1'b0;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      fc_r    <= fc_nxt;
      len_r   <= len_nxt;
      lv_r    <= lv_nxt;
      crc_r   <= crc_nxt;
      lo_r    <= lo_nxt;
      match_r <= match_nxt;
    end
  end

endmodule

@@ dv/modbus_rtu_request_frame_checker_unit_tb.sv @@
// Self-checking testbench of the Modbus RTU request frame checker: directed rows, then random frames.
`timescale 1ns / 1ps

module modbus_rtu_request_frame_checker_unit_tb;
  import mrfc_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 11;
  localparam int IdleLimit   = 1000;
  localparam int RandItems   = 200;
  localparam int HoldCycles  = 60;
  localparam int DrainCycles = 8;
  localparam int SatBytes    = 520;

  // One row of the directed table; want is used only where typed is set.
  typedef struct {
    logic [ByteW-1:0] data;
    logic             start;
    bit               typed;
    out_item_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mrfc_in_if  in_req ();
  mrfc_out_if out_rsp ();

  modbus_rtu_request_frame_checker_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #HalfPeriod clk = ~clk;

  // Frame state mirrored by the predictor.
  logic [CntW-1:0]  rx_count;
  logic [ByteW-1:0] rx_func;
  logic [CntW-1:0]  rx_len;
  logic             rx_len_known;
  logic [CrcW-1:0]  rx_crc;
  logic [ByteW-1:0] rx_crc_lo;
  logic             rx_crc_ok;

  out_item_t pending_results[$];
  stim_row_t stim_tab[$];
  int        fail_count = 0;
  int        sent_count = 0;
  int        hold_req = 0;
  int        quiet_left = 0;

  // Standard Modbus CRC-16 update with one byte, reflected polynomial.
  function automatic logic [CrcW-1:0] modbus_crc_byte(logic [CrcW-1:0] crc, logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic bit code_known(logic [ByteW-1:0] fc);
    return fc == FcReadHolding || fc == FcWriteSingle || fc == FcWriteMulti || fc == FcUser41;
  endfunction

  function automatic void clear_frame();
    rx_count     = '0;
    rx_func      = '0;
    rx_len       = '0;
    rx_len_known = 1'b0;
    rx_crc       = CrcInit;
    rx_crc_lo    = '0;
    rx_crc_ok    = 1'b0;
  endfunction

  // Advances the mirrored frame state by one byte and returns the result it reports.
  function automatic out_item_t frame_check_step(logic [ByteW-1:0] b, logic s);
    logic [CntW-1:0] idx;
    out_item_t       r;
    bit              done;
    if (s) begin
      clear_frame();
    end
    if (s || !(rx_len_known && rx_count >= rx_len)) begin
      idx = rx_count;
      // The length is fixed by the byte that decides it.
      if (idx == IdxFuncCode) begin
        rx_func = b;
        if (b == FcReadHolding || b == FcWriteSingle) begin
          rx_len       = LenFixed;
          rx_len_known = 1'b1;
        end
      end else if (idx == IdxUserCount && rx_func == FcUser41) begin
        rx_len       = LenUserBase + {1'b0, b};
        rx_len_known = 1'b1;
      end else if (idx == IdxMultiCnt && rx_func == FcWriteMulti) begin
        rx_len       = LenMultiBase + {1'b0, b};
        rx_len_known = 1'b1;
      end
      // The last two bytes carry the received CRC, low byte first.
      if (rx_len_known && rx_len >= LenCrcBytes && idx >= rx_len - LenCrcBytes) begin
        if (idx == rx_len - LenCrcBytes) begin
          rx_crc_lo = b;
        end else if (idx == rx_len - 9'd1) begin
          rx_crc_ok = (rx_crc == {b, rx_crc_lo});
        end
      end else begin
        rx_crc = modbus_crc_byte(rx_crc, b);
      end
      if (rx_count != CntMax) begin
        rx_count = rx_count + 9'd1;
      end
    end
    done = rx_len_known && rx_count >= rx_len;
    if (rx_count < 9'd2) begin
      r.status = ST_SHORT;
    end else if (!code_known(rx_func)) begin
      r.status = ST_UNSUPPORTED;
    end else if (done) begin
      r.status = ST_COMPLETE;
    end else begin
      r.status = ST_INCOMPLETE;
    end
    r.expected_length = rx_len_known ? rx_len : '0;
    r.length_known    = rx_len_known;
    r.crc_good        = done && rx_crc_ok;
    r.bytes_seen      = rx_count;
    return r;
  endfunction

  function automatic out_item_t mk_res(status_t st, int len, bit known, bit good, int seen);
    out_item_t r;
    r.status          = st;
    r.expected_length = CntW'(len);
    r.length_known    = known;
    r.crc_good        = good;
    r.bytes_seen      = CntW'(seen);
    return r;
  endfunction

  function automatic void add_row(logic [ByteW-1:0] b, logic s, bit typed, out_item_t want);
    stim_row_t row;
    row.data  = b;
    row.start = s;
    row.typed = typed;
    row.want  = want;
    stim_tab.push_back(row);
  endfunction

  // Byte count of a random frame: mostly short, now and then up to the maximum.
  function automatic logic [ByteW-1:0] draw_count();
    return ($urandom_range(0, 19) == 0) ? ByteW'($urandom_range(0, 255))
                                        : ByteW'($urandom_range(0, 6));
  endfunction

  // Offers one request after a random gap and records its expected result on acceptance.
  task automatic send_request(input logic [ByteW-1:0] b, input logic s, input bit typed,
                              input out_item_t want);
    int        gap;
    out_item_t pred;
    gap = (quiet_left > 0) ? 0 : $urandom_range(0, 4);
    if (quiet_left > 0) quiet_left--;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.data_byte   <= b;
    in_req.frame_start <= s;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    pred = frame_check_step(b, s);
    pending_results.push_back(typed ? want : pred);
    sent_count++;
  endtask

  // Builds one random frame, mostly well formed, sometimes unsupported, corrupted, cut short or padded; or sends noise.
  task automatic send_frame();
    logic [ByteW-1:0] body[$];
    logic [CrcW-1:0]  crc;
    logic [ByteW-1:0] fc;
    logic [ByteW-1:0] cnt;
    int               kind;
    int               cut;
    int               pos;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 4) == 0) quiet_left = 12;
    // Noise: loose bytes with random frame start flags.
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) begin
        send_request(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      return;
    end
    case (kind)
      0, 1: fc = FcReadHolding;
      2, 3: fc = FcWriteSingle;
      4, 5: fc = FcWriteMulti;
      6, 7: fc = FcUser41;
      default: begin
        do fc = ByteW'($urandom_range(0, 255)); while (code_known(fc));
      end
    endcase
    body.push_back(ByteW'($urandom_range(0, 255)));
    body.push_back(fc);
    if (fc == FcReadHolding || fc == FcWriteSingle) begin
      repeat (4) body.push_back(ByteW'($urandom_range(0, 255)));
    end else if (fc == FcUser41) begin
      cnt = draw_count();
      body.push_back(cnt);
      repeat (cnt) body.push_back(ByteW'($urandom_range(0, 255)));
    end else if (fc == FcWriteMulti) begin
      repeat (4) body.push_back(ByteW'($urandom_range(0, 255)));
      cnt = draw_count();
      body.push_back(cnt);
      repeat (cnt) body.push_back(ByteW'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 10)) body.push_back(ByteW'($urandom_range(0, 255)));
    end
    crc = CrcInit;
    foreach (body[i]) crc = modbus_crc_byte(crc, body[i]);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    // Flip one bit somewhere so the CRC check fails.
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, body.size() - 1);
      body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    cut = body.size();
    if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, body.size());
    for (int i = 0; i < cut; i++) begin
      send_request(body[i], i == 0, 1'b0, '0);
    end
    // Trailing bytes sometimes follow the frame; after a complete frame they leave the result unchanged.
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) send_request(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    end
  endtask

  // Stimulus: reset, directed table, random frames, then drain.
  initial begin
    int  rand_base;
    bit  held;
    bit  paused;
    in_req.valid       = 1'b0;
    in_req.data_byte   = '0;
    in_req.frame_start = 1'b0;
    out_rsp.ready      = 1'b0;
    clear_frame();
    held   = 1'b0;
    paused = 1'b0;

    // First byte after reset without a frame start counts as byte 0.
    add_row(8'h00, 1'b0, 1'b1, mk_res(ST_SHORT, 0, 0, 0, 1));
    add_row(8'hFF, 1'b1, 1'b1, mk_res(ST_SHORT, 0, 0, 0, 1));
    add_row(8'h00, 1'b0, 1'b1, mk_res(ST_UNSUPPORTED, 0, 0, 0, 2));
    // Read holding registers with a good CRC.
    add_row(8'h01, 1'b1, 1'b1, mk_res(ST_SHORT, 0, 0, 0, 1));
    add_row(8'h03, 1'b0, 1'b1, mk_res(ST_INCOMPLETE, 8, 1, 0, 2));
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h0A, 1'b0, 1'b0, '0);
    add_row(8'hC5, 1'b0, 1'b0, '0);
    add_row(8'hCD, 1'b0, 1'b1, mk_res(ST_COMPLETE, 8, 1, 1, 8));
    // A byte after completion repeats the result.
    add_row(8'hFF, 1'b0, 1'b1, mk_res(ST_COMPLETE, 8, 1, 1, 8));
    // Write single register, then a new frame starts in the middle of it.
    add_row(8'h01, 1'b1, 1'b0, '0);
    add_row(8'h06, 1'b0, 1'b1, mk_res(ST_INCOMPLETE, 8, 1, 0, 2));
    // User code with the largest byte count.
    add_row(8'h22, 1'b1, 1'b0, '0);
    add_row(8'h41, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, mk_res(ST_INCOMPLETE, 260, 1, 0, 3));
    // Write multiple registers with the largest byte count.
    add_row(8'h01, 1'b1, 1'b0, '0);
    add_row(8'h10, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, mk_res(ST_INCOMPLETE, 264, 1, 0, 7));

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_tab[i]) begin
      send_request(stim_tab[i].data, stim_tab[i].start, stim_tab[i].typed, stim_tab[i].want);
    end

    // One long unsupported frame drives the byte counter into saturation.
    send_request(8'h01, 1'b1, 1'b0, '0);
    send_request(8'h7F, 1'b0, 1'b0, '0);
    repeat (SatBytes) send_request(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0, '0);

    rand_base = sent_count;
    while (sent_count - rand_base < RandItems) begin
      // Receiver holds off while requests keep coming, so the input stalls.
      if (!held && sent_count - rand_base >= RandItems / 3) begin
        hold_req   = HoldCycles;
        quiet_left = 30;
        held       = 1'b1;
      end
      // Sender pauses until every result is back.
      if (!paused && sent_count - rand_base >= 2 * RandItems / 3) begin
        in_req.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      send_frame();
    end
    in_req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches and one long hold-off on request.
  initial begin
    int        stall;
    int        calm;
    out_item_t want;
    calm = 0;
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else if (calm > 0) begin
        stall = 0;
        calm--;
      end else begin
        stall = $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0) calm = 24;
      end
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      @(posedge clk);
      while (!(out_rsp.valid && rst_n)) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp.status);
          fail_count++;
        end
        if (out_rsp.expected_length !== want.expected_length) begin
          $error("expected_length: expected %0d, actual %0d",
                 want.expected_length, out_rsp.expected_length);
          fail_count++;
        end
        if (out_rsp.length_known !== want.length_known) begin
          $error("length_known: expected %0d, actual %0d", want.length_known, out_rsp.length_known);
          fail_count++;
        end
        if (out_rsp.crc_good !== want.crc_good) begin
          $error("crc_good: expected %0d, actual %0d", want.crc_good, out_rsp.crc_good);
          fail_count++;
        end
        if (out_rsp.bytes_seen !== want.bytes_seen) begin
          $error("bytes_seen: expected %0d, actual %0d", want.bytes_seen, out_rsp.bytes_seen);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/mrfc_pkg.sv
sv/mrfc_if.sv
sv/mrfc_crc8.sv
sv/mrfc_frame_track.sv
sv/modbus_rtu_request_frame_checker_unit.sv
dv/modbus_rtu_request_frame_checker_unit_tb.sv
